// File: rtl/core/readers_writer_lock_manager_top_macros.svh
// Assertion macros shared by the lock manager checker.
`ifndef READERS_WRITER_LOCK_MANAGER_TOP_MACROS_SVH
`define READERS_WRITER_LOCK_MANAGER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RWLM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RWLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/rwlm_pkg.sv
// Types and constants shared by the readers-writer lock manager.
`default_nettype none

package rwlm_pkg;

   localparam int OP_W     = 3;
   localparam int ID_W     = 4;
   localparam int TMO_W    = 16;
   localparam int KIND_W   = 3;
   localparam int COUNT_W  = 5;
   localparam int WENTRY_W = ID_W + 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

   typedef enum logic [OP_W-1:0] {
      OP_ENTER_READ  = 3'd0,
      OP_ENTER_WRITE = 3'd1,
      OP_EXIT_READ   = 3'd2,
      OP_EXIT_WRITE  = 3'd3,
      OP_TIMEOUT     = 3'd4
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ENTERED   = 3'd0,
      KIND_QUEUED    = 3'd1,
      KIND_RELEASED  = 3'd2,
      KIND_GRANTED   = 3'd3,
      KIND_TIMEDOUT  = 3'd4,
      KIND_IGNORED   = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_WAKE_WRITER,
      ST_DRAIN,
      ST_SCAN
   } state_type;

   // Queue command: rotation moves the head to the tail (keep) or discards it (drop).
   typedef struct packed {
      logic push;
      logic pop;
      logic rot_keep;
      logic rot_drop;
   } q_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef struct packed {
      logic shift;
      logic wrap;
      logic append;
   } cell_ctl_type;

endpackage

`default_nettype wire

// File: rtl/core/rwlm_queue_cell.sv
// One queue cell: holds an entry and takes its upper neighbor's entry on a shift.
`default_nettype none

module rwlm_queue_cell
   import rwlm_pkg::*;
#(
   parameter int W     = 4,
   parameter int IW    = 4,
   parameter int INDEX = 0
) (
   input  wire logic          clock,
   input  wire cell_ctl_type  ctl,
   input  wire logic [IW-1:0] tail,
   input  wire logic [W-1:0]  head_data,
   input  wire logic [W-1:0]  next_data,
   input  wire logic [W-1:0]  append_data,
   output logic      [W-1:0]  data_out
);

   logic [W-1:0] data_ff;
   logic [W-1:0] data_in;
   logic         hit;

   assign hit = (tail == IW'(INDEX));

   always_comb begin
      data_in = data_ff;
      if (ctl.shift) begin
         data_in = (ctl.wrap && hit) ? head_data : next_data;
      end else if (ctl.append && hit) begin
         data_in = append_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

// File: rtl/core/rwlm_queue.sv
// FIFO built as a row of shifting cells, oldest entry in cell zero, with a fill count.
`default_nettype none

module rwlm_queue
   import rwlm_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int W     = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire q_cmd_type                    cmd,
   input  wire logic [W-1:0]                 push_data,
   output logic      [W-1:0]                 head_data,
   output logic      [$clog2(DEPTH+1)-1:0]   fill,
   output q_status_type                      status
);

   localparam int FW = $clog2(DEPTH + 1);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [FW-1:0] fill_ff;
   logic [FW-1:0] fill_in;
   logic [FW-1:0] tail_wide;
   logic [IW-1:0] tail;
   cell_ctl_type  ctl;
   logic [W-1:0]  data [DEPTH];

   // A push lands just past the last entry; a kept head goes to the last slot.
   assign tail_wide  = cmd.push ? fill_ff : (fill_ff - FW'(1));
   assign tail       = tail_wide[IW-1:0];
   assign ctl.shift  = cmd.pop | cmd.rot_keep | cmd.rot_drop;
   assign ctl.wrap   = cmd.rot_keep;
   assign ctl.append = cmd.push;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [W-1:0] nxt;
      if (i == DEPTH - 1) begin : g_end
         assign nxt = data[i];
      end else begin : g_mid
         assign nxt = data[i+1];
      end
      rwlm_queue_cell #(
         .W     (W),
         .IW    (IW),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .tail        (tail),
         .head_data   (data[0]),
         .next_data   (nxt),
         .append_data (push_data),
         .data_out    (data[i])
      );
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.push) begin
         fill_in = fill_ff + FW'(1);
      end else if (cmd.pop || cmd.rot_drop) begin
         fill_in = fill_ff - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign head_data    = data[0];
   assign fill         = fill_ff;
   assign status.empty = (fill_ff == '0);
   assign status.full  = (fill_ff == FW'(DEPTH));

endmodule

`default_nettype wire

// File: rtl/core/readers_writer_lock_manager_top.sv
// Readers-writer lock manager with writer preference: controller and two cell queues.
//
// Usage: a lock event (operation, thread id, writer timeout) is taken at a clock edge
// where start is high and busy is low. Each event produces one or more result words on
// the rsp_ ports, one per cycle, each marked by rsp_valid for exactly one cycle; the
// final word of an event has rsp_last set. The receiver cannot stall, so every word
// must be taken in the cycle it is shown.
// The first result word is computed in the decide state and registered onto the rsp_
// ports. A wake adds one word per cycle: an exit_write that grants N queued readers
// produces N+1 words on consecutive cycles. A writer timeout rotates the whole writer
// queue through its head cell, one entry per cycle, and shows its single word after
// the last entry has passed (from the decide state itself if no writer waits).
// Back-to-back events: busy drops in the cycle the final word is shown, so the next
// event can be taken in that cycle.
// Reset (synchronous, active high) empties both queues, clears the reader count and the
// writer-active flag, and returns the controller to idle.
`default_nettype none

module readers_writer_lock_manager_top
   import rwlm_pkg::*;
#(
   parameter int THREADS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [OP_W-1:0]   req_operation,
   input  wire logic [ID_W-1:0]   req_thread_id,
   input  wire logic [TMO_W-1:0]  req_timeout_ms,
   output logic                   rsp_valid,
   output logic      [KIND_W-1:0] rsp_kind,
   output logic      [ID_W-1:0]   rsp_who,
   output logic      [TMO_W-1:0]  rsp_arm_timer_ms,
   output logic                   rsp_cancel_timer,
   output logic                   rsp_last
);

   localparam int FW = $clog2(THREADS + 1);

   state_type           state_ff, state_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [TMO_W-1:0]    tmo_ff, tmo_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                wactive_ff, wactive_in;
   logic                found_ff, found_in;
   logic [FW-1:0]       remain_ff, remain_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]     rsp_who_ff, rsp_who_in;
   logic [TMO_W-1:0]    rsp_arm_ff, rsp_arm_in;
   logic                rsp_cancel_ff, rsp_cancel_in;
   logic                rsp_last_ff, rsp_last_in;

   q_cmd_type           rcmd, wcmd;
   q_status_type        rstat, wstat;
   logic [ID_W-1:0]     rhead;
   logic [WENTRY_W-1:0] whead;
   logic [WENTRY_W-1:0] wpush;
   logic [FW-1:0]       rfill, wfill;
   logic [COUNT_W-1:0]  count_inc;
   logic                accept;
   logic                match;

   rwlm_queue #(
      .DEPTH (THREADS),
      .W     (ID_W)
   ) u_readers (
      .clock     (clock),
      .reset     (reset),
      .cmd       (rcmd),
      .push_data (id_ff),
      .head_data (rhead),
      .fill      (rfill),
      .status    (rstat)
   );

   // Writer entries carry the timed flag above the thread id.
   assign wpush = {(tmo_ff != '0), id_ff};

   rwlm_queue #(
      .DEPTH (THREADS),
      .W     (WENTRY_W)
   ) u_writers (
      .clock     (clock),
      .reset     (reset),
      .cmd       (wcmd),
      .push_data (wpush),
      .head_data (whead),
      .fill      (wfill),
      .status    (wstat)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : (count_ff + COUNT_W'(1));
   assign match     = whead[ID_W] && (whead[ID_W-1:0] == id_ff) && !found_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = accept ? req_operation : op_ff;
      id_in         = accept ? req_thread_id : id_ff;
      tmo_in        = accept ? req_timeout_ms : tmo_ff;
      count_in      = count_ff;
      wactive_in    = wactive_ff;
      found_in      = found_ff;
      remain_in     = remain_ff;
      rcmd          = '0;
      wcmd          = '0;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = KIND_IGNORED;
      rsp_who_in    = id_ff;
      rsp_arm_in    = '0;
      rsp_cancel_in = 1'b0;
      rsp_last_in   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
            case (op_ff)
               OP_ENTER_READ: begin
                  if (wactive_ff || !wstat.empty) begin
                     if (!rstat.full) begin
                        rcmd.push   = 1'b1;
                        rsp_kind_in = KIND_QUEUED;
                     end
                  end else begin
                     count_in    = count_inc;
                     rsp_kind_in = KIND_ENTERED;
                  end
               end
               OP_ENTER_WRITE: begin
                  if ((count_ff != '0) || wactive_ff) begin
                     if (!wstat.full) begin
                        wcmd.push   = 1'b1;
                        rsp_kind_in = KIND_QUEUED;
                        rsp_arm_in  = tmo_ff;
                     end
                  end else begin
                     wactive_in  = 1'b1;
                     rsp_kind_in = KIND_ENTERED;
                  end
               end
               OP_EXIT_READ: begin
                  rsp_kind_in = KIND_RELEASED;
                  if (count_ff != '0) begin
                     count_in = count_ff - COUNT_W'(1);
                  end
                  // The count ends at zero when it was zero or one before.
                  if ((count_ff <= COUNT_W'(1)) && !wactive_ff && !wstat.empty) begin
                     rsp_last_in = 1'b0;
                     state_in    = ST_WAKE_WRITER;
                  end
               end
               OP_EXIT_WRITE: begin
                  rsp_kind_in = KIND_RELEASED;
                  wactive_in  = 1'b0;
                  if (!rstat.empty) begin
                     rsp_last_in = 1'b0;
                     state_in    = ST_DRAIN;
                  end else if (!wstat.empty) begin
                     rsp_last_in = 1'b0;
                     state_in    = ST_WAKE_WRITER;
                  end
               end
               OP_TIMEOUT: begin
                  if (!wstat.empty) begin
                     rsp_valid_in = 1'b0;
                     rsp_last_in  = 1'b0;
                     remain_in    = wfill;
                     found_in     = 1'b0;
                     state_in     = ST_SCAN;
                  end
               end
               default: begin
                  rsp_kind_in = KIND_IGNORED;
               end
            endcase
         end

         ST_WAKE_WRITER: begin
            wcmd.pop      = 1'b1;
            wactive_in    = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = KIND_GRANTED;
            rsp_who_in    = whead[ID_W-1:0];
            rsp_cancel_in = whead[ID_W];
            rsp_last_in   = 1'b1;
            state_in      = ST_IDLE;
         end

         ST_DRAIN: begin
            rcmd.pop     = 1'b1;
            count_in     = count_inc;
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_GRANTED;
            rsp_who_in   = rhead;
            if (rfill == FW'(1)) begin
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end

         ST_SCAN: begin
            // Every queued writer passes the head once; the first timed match is dropped.
            wcmd.rot_drop = match;
            wcmd.rot_keep = !match;
            found_in      = found_ff | match;
            remain_in     = remain_ff - FW'(1);
            if (remain_ff == FW'(1)) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = found_in ? KIND_TIMEDOUT : KIND_IGNORED;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         wactive_ff   <= 1'b0;
         found_ff     <= 1'b0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wactive_ff   <= wactive_in;
         found_ff     <= found_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      tmo_ff        <= tmo_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_who_ff    <= rsp_who_in;
      rsp_arm_ff    <= rsp_arm_in;
      rsp_cancel_ff <= rsp_cancel_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_who          = rsp_who_ff;
   assign rsp_arm_timer_ms = rsp_arm_ff;
   assign rsp_cancel_timer = rsp_cancel_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/core/rwlm_checker.sv
// Port-level checker for the lock manager and its bind to the top level.
`default_nettype none
`include "readers_writer_lock_manager_top_macros.svh"

module rwlm_checker
   import rwlm_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic [OP_W-1:0]   req_operation,
   input wire logic [ID_W-1:0]   req_thread_id,
   input wire logic [TMO_W-1:0]  req_timeout_ms,
   input wire logic              rsp_valid,
   input wire logic [KIND_W-1:0] rsp_kind,
   input wire logic [ID_W-1:0]   rsp_who,
   input wire logic [TMO_W-1:0]  rsp_arm_timer_ms,
   input wire logic              rsp_cancel_timer,
   input wire logic              rsp_last
);

   logic kind_queued;
   logic kind_granted;
   logic req_seen;

   assign kind_queued  = (rsp_kind == KIND_QUEUED);
   assign kind_granted = (rsp_kind == KIND_GRANTED);
   // Keeps the request payload and result id in the checker's view.
   assign req_seen     = (|req_operation) | (|req_thread_id) | (|req_timeout_ms) | (|rsp_who);

   `RWLM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted word did not raise busy")
   `RWLM_ASSERT_IMP(a_arm_queued, clock, reset, rsp_valid && !kind_queued, rsp_arm_timer_ms == '0, "timer armed on a word that is not queued")
   `RWLM_ASSERT_IMP(a_cancel_granted, clock, reset, rsp_valid && rsp_cancel_timer, kind_granted, "timer cancel on a word that is not a grant")
   `RWLM_ASSERT_NEXT(a_burst_contiguous, clock, reset, rsp_valid && !rsp_last && (req_seen || !req_seen), rsp_valid, "result burst broken before its last word")

endmodule

bind readers_writer_lock_manager_top rwlm_checker u_rwlm_checker (.*);

`default_nettype wire
